[rtl/bba_pkg.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// bba_pkg
// Shared types, constants and index helpers for the buddy block allocator.
// ---------------------------------------------------------------------------
package bba_pkg;

  localparam int SPACE_LOG2      = 16;
  localparam int MIN_BLOCK_BYTES = 16;
  localparam int LEVELS          = 13;
  localparam int HEADER_BYTES    = 8;

  localparam int NBLK      = 1 << (LEVELS - 1);
  localparam int BLK_W     = LEVELS - 1;
  localparam int BLK_SHIFT = SPACE_LOG2 - LEVELS + 1;
  localparam int ID_W      = LEVELS;
  localparam int NODE_W    = LEVELS;
  localparam int LVL_W     = $clog2(LEVELS);
  localparam int ADDR_W    = SPACE_LOG2;
  localparam int REQ_W     = SPACE_LOG2 + 1;
  localparam int SIZE_W    = 16;

  localparam logic       FUNC_ALLOC   = 1'b0;
  localparam logic       FUNC_FREE    = 1'b1;
  localparam logic [1:0] ST_DONE      = 2'd0;
  localparam logic [1:0] ST_TOO_LARGE = 2'd1;
  localparam logic [1:0] ST_NO_FREE   = 2'd2;

  localparam logic FLD_PREV = 1'b0;
  localparam logic FLD_NEXT = 1'b1;

  typedef struct packed {
    logic        func;
    logic [15:0] request_bytes;
    logic [15:0] block_offset;
  } bba_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] result_offset;
  } bba_out_t;

  typedef struct packed {
    logic              lrd;
    logic              lwr;
    logic              lfld;
    logic [ID_W-1:0]   lid;
    logic [ID_W-1:0]   lval;
    logic              srd;
    logic              swr;
    logic [BLK_W-1:0]  sidx;
    logic              sval;
    logic              zwr;
    logic [BLK_W-1:0]  zidx;
    logic [SIZE_W-1:0] zval;
  } bba_cmd_t;

  typedef struct packed {
    logic [ID_W-1:0]   lprev;
    logic [ID_W-1:0]   lnext;
    logic              sbit;
    logic [SIZE_W-1:0] zsize;
    logic              clr_busy;
  } bba_sts_t;

  function automatic logic [LVL_W-1:0] bucket_for(input logic [REQ_W-1:0] req);
    logic [LVL_W-1:0] b;
    b = LVL_W'(LEVELS - 1);
    for (int k = 0; k < LEVELS - 1; k++) begin
      if ((64'(MIN_BLOCK_BYTES) << k) < 64'(req)) b = LVL_W'(LEVELS - 2 - k);
    end
    return b;
  endfunction

  function automatic logic [BLK_W-1:0] blk_of(input logic [ADDR_W-1:0] addr);
    return BLK_W'(addr >> BLK_SHIFT);
  endfunction

  function automatic logic [ADDR_W-1:0] addr_of_blk(input logic [BLK_W-1:0] id);
    return ADDR_W'({20'b0, id} << BLK_SHIFT);
  endfunction

  function automatic logic [NODE_W-1:0] node_for_addr(input logic [ADDR_W-1:0] addr,
                                                      input logic [LVL_W-1:0] b);
    logic [31:0] t;
    t = (32'(addr) >> (SPACE_LOG2 - int'(b))) + (32'd1 << b) - 32'd1;
    return NODE_W'(t);
  endfunction

  function automatic logic [ADDR_W-1:0] addr_for_node(input logic [NODE_W-1:0] i,
                                                      input logic [LVL_W-1:0] b);
    logic [31:0] t;
    t = (32'(i) + 32'd1 - (32'd1 << b)) << (SPACE_LOG2 - int'(b));
    return ADDR_W'(t);
  endfunction

  function automatic logic [BLK_W-1:0] parent_of(input logic [NODE_W-1:0] i);
    logic [NODE_W-1:0] t;
    t = i - NODE_W'(1);
    return BLK_W'(t >> 1);
  endfunction

  function automatic logic [NODE_W-1:0] root_node(input logic [LVL_W-1:0] b);
    return NODE_W'((32'd1 << b) - 32'd1);
  endfunction

  function automatic logic [ID_W-1:0] head_id(input logic [LVL_W-1:0] b);
    return ID_W'(NBLK) + ID_W'(b);
  endfunction

endpackage
`default_nettype wire

[rtl/bba_store.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// bba_store
// Datapath: link table, bucket heads, split bits and stored sizes, with a
// clearing sweep after reset that clears the split bits and links block zero into the top bucket.
// ---------------------------------------------------------------------------
module bba_store import bba_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  bba_cmd_t cmd,
  output bba_sts_t sts
);

  logic [ID_W-1:0]   link_prev_m [NBLK];
  logic [ID_W-1:0]   link_next_m [NBLK];
  logic              split_m     [NBLK];
  logic [SIZE_W-1:0] size_m      [NBLK];

  logic [ID_W-1:0] head_prev_r [LEVELS];
  logic [ID_W-1:0] head_next_r [LEVELS];

  logic              clr_busy_r;
  logic [BLK_W-1:0]  clr_idx_r;
  logic [ID_W-1:0]   rd_prev_r, rd_next_r, hd_prev_r, hd_next_r;
  logic              hsel_r;
  logic              sbit_r;
  logic [SIZE_W-1:0] zsize_r;

  logic             id_head;
  logic [LVL_W-1:0] hidx;
  logic [BLK_W-1:0] madr;
  logic             lp_we, ln_we;
  logic [BLK_W-1:0] lw_adr;
  logic [ID_W-1:0]  lw_val;
  logic             s_we;
  logic [BLK_W-1:0] s_adr;
  logic             s_val;

  // ids past the heads fall back to block zero
  always_comb begin
    id_head = (cmd.lid >= ID_W'(NBLK)) && (cmd.lid < ID_W'(NBLK + LEVELS));
    hidx    = id_head ? LVL_W'(cmd.lid - ID_W'(NBLK)) : '0;
    madr    = (cmd.lid < ID_W'(NBLK)) ? cmd.lid[BLK_W-1:0] : '0;
  end

  always_comb begin
    lp_we  = cmd.lwr && !id_head && (cmd.lfld == FLD_PREV);
    ln_we  = cmd.lwr && !id_head && (cmd.lfld == FLD_NEXT);
    lw_adr = madr;
    lw_val = cmd.lval;
    s_we   = cmd.swr;
    s_adr  = cmd.sidx;
    s_val  = cmd.sval;
    if (clr_busy_r) begin
      s_we  = 1'b1;
      s_adr = clr_idx_r;
      s_val = 1'b0;
      lp_we = (clr_idx_r == '0);
      ln_we = (clr_idx_r == '0);
      lw_adr = '0;
      lw_val = head_id(LVL_W'(LEVELS - 1));
    end
  end

  always_ff @(posedge clk) begin
    if (lp_we) link_prev_m[lw_adr] <= lw_val;
    if (ln_we) link_next_m[lw_adr] <= lw_val;
    if (s_we) split_m[s_adr] <= s_val;
    if (cmd.zwr) size_m[cmd.zidx] <= cmd.zval;
    if (cmd.lrd) begin
      rd_prev_r <= link_prev_m[madr];
      rd_next_r <= link_next_m[madr];
      hd_prev_r <= head_prev_r[hidx];
      hd_next_r <= head_next_r[hidx];
      hsel_r    <= id_head;
    end
    if (cmd.srd) sbit_r <= split_m[cmd.sidx];
    zsize_r <= size_m[cmd.zidx];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int b = 0; b < LEVELS - 1; b++) begin
        head_prev_r[b] <= head_id(LVL_W'(b));
        head_next_r[b] <= head_id(LVL_W'(b));
      end
      head_prev_r[LEVELS-1] <= '0;
      head_next_r[LEVELS-1] <= '0;
      clr_busy_r <= 1'b1;
      clr_idx_r  <= '0;
    end else begin
      if (cmd.lwr && id_head) begin
        if (cmd.lfld == FLD_PREV) head_prev_r[hidx] <= cmd.lval;
        else head_next_r[hidx] <= cmd.lval;
      end
      if (clr_busy_r) begin
        clr_idx_r <= clr_idx_r + BLK_W'(1);
        if (clr_idx_r == '1) clr_busy_r <= 1'b0;
      end
    end
  end

  always_comb begin
    sts.lprev    = hsel_r ? hd_prev_r : rd_prev_r;
    sts.lnext    = hsel_r ? hd_next_r : rd_next_r;
    sts.sbit     = sbit_r;
    sts.zsize    = zsize_r;
    sts.clr_busy = clr_busy_r;
  end

  a_no_wr_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy_r |-> !cmd.lwr && !cmd.swr && !cmd.zwr)
    else $error("store command during clearing sweep");

  a_clear_ends: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy_r && (clr_idx_r == '1) |=> !clr_busy_r)
    else $error("clearing sweep did not finish");

  a_clear_once: assert property (@(posedge clk) disable iff (!rst_n)
    !clr_busy_r |=> !clr_busy_r)
    else $error("clearing sweep restarted");

endmodule
`default_nettype wire

[rtl/bba_ctrl.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// bba_ctrl
// Sequencer: walks allocate and free through list, split and size commands.
// ---------------------------------------------------------------------------
module bba_ctrl import bba_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  bba_in_t  in_word,
  output logic     out_valid,
  input  logic     out_stall,
  output bba_out_t out_word,
  output bba_cmd_t cmd,
  input  bba_sts_t sts
);

  typedef enum logic [5:0] {
    S_IDLE, S_START, S_FSZ, S_FI, S_FLOOP, S_FCHK, S_FNEXT,
    P_RD, P_W0, P_W1, P_W2, P_W3, R_RD, R_W0, R_W1, O_RD, O_CHK,
    I_W0, I_W1, F_RD, F_WR,
    G_LOOP, G_CHK, G_U1, G_U2, G_S1, G_S2,
    A_POP1, A_P1, A_POP2, A_P2, A_FOUND, A_F1, A_SPL, A_SPUSH, A_SZ,
    S_DONE
  } state_t;

  state_t state_r, ret_r, gret_r;
  bba_in_t           in_r;
  logic [ADDR_W-1:0] addr_r;
  logic [LVL_W-1:0]  b_r, orig_r, root_r, tgt_r;
  logic [NODE_W-1:0] i_r, fnode_r;
  logic [BLK_W-1:0]  id_r;
  logic [ID_W-1:0]   h_r, e_r, pv_r, nx_r;
  logic              pop_ok_r, fnew_r;
  logic [1:0]        res_status_r;
  logic [15:0]       res_off_r;
  logic              out_valid_r;
  bba_out_t          out_word_r;

  logic [NODE_W-1:0] rnode, inext, sib;
  logic [ADDR_W-1:0] faddr;
  logic              too_large;

  always_comb begin
    rnode = root_node(root_r);
    inext = {i_r[NODE_W-2:0], 1'b1};
    sib   = ((i_r - NODE_W'(1)) ^ NODE_W'(1)) + NODE_W'(1);
    faddr = in_r.block_offset - ADDR_W'(HEADER_BYTES);
    too_large = (REQ_W'(in_r.request_bytes) + REQ_W'(HEADER_BYTES)) >
                REQ_W'(64'd1 << SPACE_LOG2);
  end

  assign in_stall  = (state_r != S_IDLE) || sts.clr_busy;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  always_comb begin
    cmd = '0;
    unique case (state_r)
      P_RD, O_RD: begin cmd.lrd = 1'b1; cmd.lid = h_r; end
      R_RD:       begin cmd.lrd = 1'b1; cmd.lid = e_r; end
      P_W0: begin
        cmd.lwr = 1'b1; cmd.lfld = FLD_PREV; cmd.lid = e_r; cmd.lval = sts.lprev;
      end
      P_W1: begin cmd.lwr = 1'b1; cmd.lfld = FLD_NEXT; cmd.lid = e_r; cmd.lval = h_r; end
      P_W2: begin cmd.lwr = 1'b1; cmd.lfld = FLD_NEXT; cmd.lid = pv_r; cmd.lval = e_r; end
      P_W3: begin cmd.lwr = 1'b1; cmd.lfld = FLD_PREV; cmd.lid = h_r; cmd.lval = e_r; end
      R_W0: begin
        cmd.lwr = 1'b1; cmd.lfld = FLD_NEXT; cmd.lid = sts.lprev; cmd.lval = sts.lnext;
      end
      R_W1: begin cmd.lwr = 1'b1; cmd.lfld = FLD_PREV; cmd.lid = nx_r; cmd.lval = pv_r; end
      I_W0: begin cmd.lwr = 1'b1; cmd.lfld = FLD_PREV; cmd.lid = h_r; cmd.lval = h_r; end
      I_W1: begin cmd.lwr = 1'b1; cmd.lfld = FLD_NEXT; cmd.lid = h_r; cmd.lval = h_r; end
      F_RD: begin cmd.srd = 1'b1; cmd.sidx = parent_of(fnode_r); end
      F_WR: begin
        cmd.swr = 1'b1; cmd.sidx = parent_of(fnode_r); cmd.sval = ~sts.sbit;
      end
      G_LOOP: begin cmd.srd = (tgt_r < root_r); cmd.sidx = parent_of(rnode); end
      S_START: cmd.zidx = blk_of(faddr);
      A_SZ: begin cmd.zwr = 1'b1; cmd.zidx = id_r; cmd.zval = in_r.request_bytes; end
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ret_r       <= S_IDLE;
      gret_r      <= S_IDLE;
      root_r      <= LVL_W'(LEVELS - 1);
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall && (state_r != S_DONE)) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: if (in_valid && !in_stall) begin
          in_r    <= in_word;
          state_r <= S_START;
        end
        S_START: begin
          res_off_r    <= '0;
          res_status_r <= ((in_r.func == FUNC_ALLOC) && too_large) ? ST_TOO_LARGE : ST_DONE;
          if (in_r.func == FUNC_ALLOC) begin
            if (too_large) begin
              state_r <= S_DONE;
            end else begin
              b_r     <= bucket_for(REQ_W'(in_r.request_bytes) + REQ_W'(HEADER_BYTES));
              orig_r  <= bucket_for(REQ_W'(in_r.request_bytes) + REQ_W'(HEADER_BYTES));
              tgt_r   <= bucket_for(REQ_W'(in_r.request_bytes) + REQ_W'(HEADER_BYTES));
              gret_r  <= A_POP1;
              state_r <= G_LOOP;
            end
          end else if (in_r.block_offset == '0) begin
            state_r <= S_DONE;
          end else begin
            addr_r  <= faddr;
            state_r <= S_FSZ;
          end
        end
        S_FSZ: begin
          b_r     <= bucket_for(REQ_W'(sts.zsize) + REQ_W'(HEADER_BYTES));
          state_r <= S_FI;
        end
        S_FI: begin
          i_r     <= node_for_addr(addr_r, b_r);
          state_r <= S_FLOOP;
        end
        S_FLOOP: if (i_r == '0) begin
          h_r <= head_id(b_r);
          e_r <= ID_W'(blk_of(addr_for_node(i_r, b_r)));
          ret_r <= S_DONE;
          state_r <= P_RD;
        end else begin
          fnode_r <= i_r;
          ret_r   <= S_FCHK;
          state_r <= F_RD;
        end
        S_FCHK: if (fnew_r || (b_r == root_r)) begin
          h_r <= head_id(b_r);
          e_r <= ID_W'(blk_of(addr_for_node(i_r, b_r)));
          ret_r <= S_DONE;
          state_r <= P_RD;
        end else begin
          // unlink the free buddy before merging
          e_r     <= ID_W'(blk_of(addr_for_node(sib, b_r)));
          ret_r   <= S_FNEXT;
          state_r <= R_RD;
        end
        S_FNEXT: begin
          i_r     <= (i_r - NODE_W'(1)) >> 1;
          b_r     <= b_r - LVL_W'(1);
          state_r <= S_FLOOP;
        end
        P_RD: state_r <= P_W0;
        P_W0: begin pv_r <= sts.lprev; state_r <= P_W1; end
        P_W1: state_r <= P_W2;
        P_W2: state_r <= P_W3;
        P_W3: state_r <= ret_r;
        R_RD: state_r <= R_W0;
        R_W0: begin
          pv_r    <= sts.lprev;
          nx_r    <= sts.lnext;
          state_r <= R_W1;
        end
        R_W1: state_r <= ret_r;
        O_RD: state_r <= O_CHK;
        O_CHK: if ((sts.lprev == h_r) || (sts.lprev >= ID_W'(NBLK))) begin
          pop_ok_r <= 1'b0;
          state_r  <= ret_r;
        end else begin
          pop_ok_r <= 1'b1;
          id_r     <= sts.lprev[BLK_W-1:0];
          e_r      <= sts.lprev;
          state_r  <= R_RD;
        end
        I_W0: state_r <= I_W1;
        I_W1: state_r <= ret_r;
        F_RD: state_r <= F_WR;
        F_WR: begin fnew_r <= ~sts.sbit; state_r <= ret_r; end
        G_LOOP: state_r <= (tgt_r < root_r) ? G_CHK : gret_r;
        G_CHK: if (!sts.sbit) begin
          e_r <= '0; ret_r <= G_U1; state_r <= R_RD;
        end else begin
          h_r <= head_id(root_r);
          e_r <= ID_W'(blk_of(addr_for_node(rnode + NODE_W'(1), root_r)));
          ret_r <= G_S1;
          state_r <= P_RD;
        end
        G_U1: begin
          root_r <= root_r - LVL_W'(1);
          h_r    <= head_id(root_r - LVL_W'(1));
          ret_r  <= G_U2;
          state_r <= I_W0;
        end
        G_U2: begin
          h_r <= head_id(root_r); e_r <= '0; ret_r <= G_LOOP; state_r <= P_RD;
        end
        G_S1: begin
          root_r <= root_r - LVL_W'(1);
          h_r    <= head_id(root_r - LVL_W'(1));
          ret_r  <= G_S2;
          state_r <= I_W0;
        end
        G_S2: if (rnode != '0) begin
          fnode_r <= rnode; ret_r <= G_LOOP; state_r <= F_RD;
        end else begin
          state_r <= G_LOOP;
        end
        A_POP1: begin h_r <= head_id(b_r); ret_r <= A_P1; state_r <= O_RD; end
        A_P1: if (pop_ok_r) begin
          state_r <= A_FOUND;
        end else if ((b_r != root_r) || (b_r == '0)) begin
          if (b_r == '0) begin
            res_status_r <= ST_NO_FREE;
            state_r      <= S_DONE;
          end else begin
            b_r     <= b_r - LVL_W'(1);
            tgt_r   <= b_r - LVL_W'(1);
            gret_r  <= A_POP1;
            state_r <= G_LOOP;
          end
        end else begin
          tgt_r   <= b_r - LVL_W'(1);
          gret_r  <= A_POP2;
          state_r <= G_LOOP;
        end
        A_POP2: begin h_r <= head_id(b_r); ret_r <= A_P2; state_r <= O_RD; end
        A_P2: if (pop_ok_r) begin
          state_r <= A_FOUND;
        end else begin
          res_status_r <= ST_NO_FREE;
          state_r      <= S_DONE;
        end
        A_FOUND: begin
          addr_r  <= addr_of_blk(id_r);
          i_r     <= node_for_addr(addr_of_blk(id_r), b_r);
          state_r <= A_F1;
        end
        A_F1: if (i_r != '0) begin
          fnode_r <= i_r; ret_r <= A_SPL; state_r <= F_RD;
        end else begin
          state_r <= A_SPL;
        end
        A_SPL: if (b_r < orig_r) begin
          // split down one level, keep the left half
          i_r     <= inext;
          b_r     <= b_r + LVL_W'(1);
          fnode_r <= inext;
          ret_r   <= A_SPUSH;
          state_r <= F_RD;
        end else begin
          state_r <= A_SZ;
        end
        A_SPUSH: begin
          h_r <= head_id(b_r);
          e_r <= ID_W'(blk_of(addr_for_node(i_r + NODE_W'(1), b_r)));
          ret_r <= A_SPL;
          state_r <= P_RD;
        end
        A_SZ: begin
          res_status_r <= ST_DONE;
          res_off_r    <= 16'(addr_r + ADDR_W'(HEADER_BYTES));
          state_r      <= S_DONE;
        end
        S_DONE: if (!out_valid_r || !out_stall) begin
          out_valid_r              <= 1'b1;
          out_word_r.status        <= res_status_r;
          out_word_r.result_offset <= res_off_r;
          state_r                  <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> state_r == S_START)
    else $error("accepted word did not start a walk");

  a_root_range: assert property (@(posedge clk) disable iff (!rst_n)
    root_r <= LVL_W'(LEVELS - 1))
    else $error("root level out of range");

  a_done_posts: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DONE && !(out_valid_r && out_stall) |=> out_valid_r)
    else $error("finished walk did not post a result");

endmodule
`default_nettype wire

[rtl/buddy_block_allocator.sv]
`default_nettype none
// Work per item: a null free or an oversize request skips the tree walk; otherwise
//   each tree level walked costs link, split and size accesses.
// Throughput: one item at a time; the single-port link table sets the pace.
// A result waits in the output register while the next word is accepted.
// Reset: synchronous active-low; afterwards a sweep over all 4096 split bits clears them
//   and no word is accepted until it ends.
// ---------------------------------------------------------------------------
// buddy_block_allocator
// Buddy allocator with per-bucket free lists, tree growth and buddy merging.
// ---------------------------------------------------------------------------
module buddy_block_allocator import bba_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  bba_in_t  in_word,
  output logic     out_valid,
  input  logic     out_stall,
  output bba_out_t out_word
);

  bba_cmd_t cmd;
  bba_sts_t sts;

  bba_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .cmd       (cmd),
    .sts       (sts)
  );

  bba_store u_store (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (cmd),
    .sts   (sts)
  );

endmodule
`default_nettype wire

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the buddy block allocator: a behavioural copy of
// the allocator tree predicts every result word, which is compared field by
// field with the block's output under random idle and stall patterns.
// ---------------------------------------------------------------------------
module tb_top;
  import bba_pkg::*;

  localparam longint unsigned SPACE_MASK = (64'd1 << SPACE_LOG2) - 1;
  localparam int CYCLE_LIMIT = 4000000;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  bba_in_t  in_word = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  bba_out_t out_word;

  buddy_block_allocator uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
    .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  int          idle_pct = 0;
  int          stall_pct = 0;
  int          hold_len = 0;
  int          errors = 0;
  int          cycles = 0;
  bba_out_t    pending_results[$];
  logic [15:0] live_offsets[$];

  // Allocator mirror
  bit              split_tbl[NBLK];
  int unsigned     head_tbl[LEVELS][2];
  int unsigned     link_tbl[NBLK][2];
  logic [15:0]     size_tbl[NBLK];
  int              root_lvl;

  function automatic int unsigned link_get(int unsigned id, int f);
    if (id < NBLK) return link_tbl[id][f];
    if (id - NBLK < LEVELS) return head_tbl[id - NBLK][f];
    return link_tbl[0][f];
  endfunction

  function automatic void link_set(int unsigned id, int f, int unsigned v);
    if (id < NBLK) link_tbl[id][f] = v;
    else if (id - NBLK < LEVELS) head_tbl[id - NBLK][f] = v;
    else link_tbl[0][f] = v;
  endfunction

  function automatic void list_clear(int unsigned h);
    link_set(h, 0, h);
    link_set(h, 1, h);
  endfunction

  function automatic void list_append(int unsigned h, int unsigned e);
    int unsigned pv;
    pv = link_get(h, 0);
    link_set(e, 0, pv);
    link_set(e, 1, h);
    link_set(pv, 1, e);
    link_set(h, 0, e);
  endfunction

  function automatic void list_unlink(int unsigned e);
    int unsigned pv, nx;
    pv = link_get(e, 0);
    nx = link_get(e, 1);
    link_set(pv, 1, nx);
    link_set(nx, 0, pv);
  endfunction

  function automatic bit list_take_last(int unsigned h, output int unsigned id);
    int unsigned last;
    last = link_get(h, 0);
    id = 0;
    if (last == h || last >= NBLK) return 1'b0;
    list_unlink(last);
    id = last;
    return 1'b1;
  endfunction

  function automatic int unsigned block_of(longint unsigned a);
    return int'(((a & SPACE_MASK) >> BLK_SHIFT) & (NBLK - 1));
  endfunction

  function automatic longint unsigned node_addr(longint unsigned i, int b);
    return ((i + 1 - (64'd1 << b)) << (SPACE_LOG2 - b)) & SPACE_MASK;
  endfunction

  function automatic longint unsigned addr_node(longint unsigned a, int b);
    return ((a & SPACE_MASK) >> (SPACE_LOG2 - b)) + (64'd1 << b) - 1;
  endfunction

  function automatic bit split_above(longint unsigned i);
    return split_tbl[((i - 1) / 2) & (NBLK - 1)];
  endfunction

  function automatic void toggle_parent(longint unsigned i);
    split_tbl[((i - 1) / 2) & (NBLK - 1)] ^= 1'b1;
  endfunction

  function automatic int size_bucket(longint unsigned req);
    int b;
    longint unsigned sz;
    b = LEVELS - 1;
    sz = MIN_BLOCK_BYTES;
    while (sz < req && b > 0) begin
      b--;
      sz *= 2;
    end
    return b;
  endfunction

  function automatic void grow_root(int target);
    longint unsigned r;
    while (target < root_lvl) begin
      r = (64'd1 << root_lvl) - 1;
      if (!split_above(r)) begin
        list_unlink(0);
        root_lvl--;
        list_clear(NBLK + root_lvl);
        list_append(NBLK + root_lvl, 0);
      end else begin
        list_append(NBLK + root_lvl, block_of(node_addr(r + 1, root_lvl)));
        root_lvl--;
        list_clear(NBLK + root_lvl);
        r = (r - 1) / 2;
        if (r != 0) toggle_parent(r);
      end
    end
  endfunction

  function automatic void allocator_reset();
    for (int k = 0; k < NBLK; k++) begin
      split_tbl[k] = 1'b0;
      link_tbl[k][0] = 0;
      link_tbl[k][1] = 0;
      size_tbl[k] = '0;
    end
    for (int b = 0; b < LEVELS; b++) list_clear(NBLK + b);
    root_lvl = LEVELS - 1;
    list_append(NBLK + LEVELS - 1, 0);
  endfunction

  function automatic bba_out_t predict_alloc(longint unsigned req);
    bba_out_t        res;
    int              orig, b;
    int unsigned     id;
    longint unsigned a, i;
    res = '0;
    if (req + HEADER_BYTES > (64'd1 << SPACE_LOG2)) begin
      res.status = ST_TOO_LARGE;
      return res;
    end
    orig = size_bucket(req + HEADER_BYTES);
    b = orig;
    while (b >= 0) begin
      grow_root(b);
      if (!list_take_last(NBLK + b, id)) begin
        if (b != root_lvl || b == 0) begin
          b--;
          continue;
        end
        grow_root(b - 1);
        if (!list_take_last(NBLK + b, id)) break;
      end
      a = (longint'(id) << BLK_SHIFT) & SPACE_MASK;
      i = addr_node(a, b);
      if (i != 0) toggle_parent(i);
      while (b < orig) begin
        i = i * 2 + 1;
        b++;
        toggle_parent(i);
        list_append(NBLK + b, block_of(node_addr(i + 1, b)));
      end
      size_tbl[id] = req[15:0];
      res.status = ST_DONE;
      res.result_offset = 16'(a + HEADER_BYTES);
      return res;
    end
    res.status = ST_NO_FREE;
    return res;
  endfunction

  function automatic void predict_free(longint unsigned off);
    longint unsigned a, i;
    int              b;
    if (off == 0) return;
    a = (off - HEADER_BYTES) & SPACE_MASK;
    b = size_bucket(longint'(size_tbl[block_of(a)]) + HEADER_BYTES);
    i = addr_node(a, b);
    while (i != 0) begin
      toggle_parent(i);
      if (split_above(i) || b == root_lvl) break;
      list_unlink(block_of(node_addr(((i - 1) ^ 1) + 1, b)));
      i = (i - 1) / 2;
      b--;
    end
    list_append(NBLK + b, block_of(node_addr(i, b)));
  endfunction

  // Offer one word, hold it until taken, then record what it must produce.
  task automatic send_word(input bba_in_t w);
    bba_out_t res;
    in_word  <= w;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    res = '0;
    if (w.func == FUNC_ALLOC) begin
      res = predict_alloc(w.request_bytes);
      if (res.status == ST_DONE) live_offsets.push_back(res.result_offset);
    end else begin
      predict_free(w.block_offset);
    end
    pending_results.push_back(res);
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic send_alloc(input logic [15:0] req);
    bba_in_t w;
    w.func = FUNC_ALLOC;
    w.request_bytes = req;
    w.block_offset = 16'($urandom);
    send_word(w);
  endtask

  task automatic send_free(input logic [15:0] off);
    bba_in_t w;
    w.func = FUNC_FREE;
    w.request_bytes = 16'($urandom);
    w.block_offset = off;
    send_word(w);
  endtask

  task automatic free_live_at(input int k);
    logic [15:0] off;
    off = live_offsets[k];
    live_offsets.delete(k);
    send_free(off);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic release_all();
    while (live_offsets.size() != 0)
      free_live_at($urandom_range(0, live_offsets.size() - 1));
  endtask

  task automatic random_item();
    int          pick;
    logic [15:0] req;
    pick = $urandom_range(99);
    if (pick < 5) begin
      send_free(16'h0000);
    end else if (live_offsets.size() != 0 &&
                 pick < (live_offsets.size() > 20 ? 60 : 38)) begin
      free_live_at($urandom_range(0, live_offsets.size() - 1));
    end else begin
      pick = $urandom_range(99);
      if (pick < 55) req = 16'($urandom_range(0, 120));
      else if (pick < 85) req = 16'($urandom_range(0, 2000));
      else if (pick < 96) req = 16'($urandom_range(0, 20000));
      else req = 16'($urandom);
      send_alloc(req);
    end
  endtask

  // Edge sizes, the whole space, oversize, exhaustion and null free.
  task automatic test_directed();
    idle_pct = 0;
    stall_pct = 0;
    send_alloc(16'd65528);
    send_alloc(16'd0);
    send_free(16'h0000);
    release_all();
    send_alloc(16'd65529);
    send_alloc(16'hFFFF);
    send_alloc(16'd0);
    send_alloc(16'd8);
    send_alloc(16'd9);
    send_alloc(16'd24);
    send_alloc(16'd25);
    send_alloc(16'd32760);
    send_alloc(16'd32761);
    send_free(16'h0000);
    release_all();
    drain_results();
  endtask

  // Fill the space with mid-size blocks until it runs out, then empty it.
  task automatic test_exhaustion();
    for (int k = 0; k < 70; k++) send_alloc(16'($urandom_range(600, 1016)));
    send_alloc(16'd0);
    release_all();
    drain_results();
  endtask

  task automatic test_random_phase(input int n, input int idle, input int stall);
    idle_pct = idle;
    stall_pct = stall;
    for (int k = 0; k < n; k++) random_item();
    drain_results();
  endtask

  // Hold the output off for a long stretch while words keep coming.
  task automatic test_backpressure();
    idle_pct = 0;
    stall_pct = 0;
    hold_len = 600;
    for (int k = 0; k < 30; k++) random_item();
    drain_results();
    release_all();
    drain_results();
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_len > 0) begin
      hold_len = hold_len - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    bba_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result word with nothing expected: status %0d offset %0d",
               out_word.status, out_word.result_offset);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (out_word.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_word.status);
          errors++;
        end
        if (out_word.result_offset !== want.result_offset) begin
          $error("result_offset: expected %0d, got %0d",
                 want.result_offset, out_word.result_offset);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    allocator_reset();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_exhaustion();
    test_random_phase(220, 0, 0);
    test_random_phase(180, 61, 0);
    test_random_phase(180, 0, 61);
    test_random_phase(180, 36, 36);
    test_backpressure();
    test_random_phase(80, 0, 0);
    release_all();
    drain_results();
    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

[files.f]
rtl/bba_pkg.sv
rtl/bba_store.sv
rtl/bba_ctrl.sv
rtl/buddy_block_allocator.sv
tb/sv/tb_top.sv
